>>> rtl/abm_pkg.sv
// Shared types and constants for the approximate bitap matcher.
`default_nettype none
package abm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int MAX_LEVELS_DEF  = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 5;
    localparam int POS_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 6;
    localparam int PLEN_W   = 6;
    localparam int KERR_W   = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TEXT  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_MAX_ERRORS     = 3'd1,
        CFG_ALLOW_INSERT   = 3'd2,
        CFG_ALLOW_DELETE   = 3'd3,
        CFG_ALLOW_SUBST    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PLEN_W-1:0] pattern_length;
        logic [KERR_W-1:0] max_errors;
        logic              allow_insert;
        logic              allow_delete;
        logic              allow_substitute;
    } t_cfg;

    typedef struct packed {
        t_cmd              cmd;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } t_item;

endpackage
`default_nettype wire

>>> rtl/abm_front.sv
// Front end: input transfer, command decode and filtering into the queue.
`default_nettype none
module abm_front #(
    parameter int PATTERN_MAX = abm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                        i_valid,
    input  wire logic [abm_pkg::CMD_W-1:0]   i_command,
    input  wire logic [abm_pkg::CHAR_W-1:0]  i_char_value,
    input  wire logic [abm_pkg::IDX_W-1:0]   i_pattern_index,
    output logic                             o_stall,
    input  wire logic                        i_full,
    output logic                             o_push,
    output abm_pkg::t_item                   o_item
);
    import abm_pkg::*;

    logic w_accept;
    logic w_keep;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;

    always_comb begin
        w_keep = 1'b0;
        unique case (t_cmd'(i_command))
            CMD_LOAD:  w_keep = (32'(i_pattern_index) < 32'(PATTERN_MAX));
            CMD_START: w_keep = 1'b1;
            CMD_TEXT:  w_keep = 1'b1;
            default:   w_keep = 1'b0;
        endcase
    end

    assign o_push     = w_accept && w_keep;
    assign o_item.cmd = t_cmd'(i_command);
    assign o_item.ch  = i_char_value;
    assign o_item.idx = i_pattern_index;

endmodule
`default_nettype wire

>>> rtl/abm_queue.sv
// Short FIFO between the front end and the matcher core.
`default_nettype none
module abm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  abm_pkg::t_item      i_push_item,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output abm_pkg::t_item      o_head
);
    import abm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/abm_back.sv
// Matcher core: pattern store, error-level vectors, text position and result register.
`default_nettype none
module abm_back #(
    parameter int PATTERN_MAX = abm_pkg::PATTERN_MAX_DEF,
    parameter int MAX_LEVELS  = abm_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  abm_pkg::t_cfg                   i_cfg,
    input  wire logic                       i_empty,
    input  abm_pkg::t_item                  i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [abm_pkg::POS_W-1:0]       o_match_end_position
);
    import abm_pkg::*;

    localparam int SW = $clog2(PATTERN_MAX);
    localparam int MW = $clog2(PATTERN_MAX + 1);
    localparam int KW = $clog2(MAX_LEVELS + 1);

    logic [CHAR_W-1:0]      r_store [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_lv [MAX_LEVELS+1];
    logic [POS_W-1:0]       r_pos;
    logic                   r_out_valid;
    logic [POS_W-1:0]       r_out_pos;

    logic [MW-1:0]          w_m;
    logic [KW-1:0]          w_k;
    logic [MW-1:0]          w_shift;
    logic [PATTERN_MAX-1:0] w_eq;
    logic [PATTERN_MAX-1:0] w_rev;
    logic [PATTERN_MAX-1:0] w_cmask;
    logic [PATTERN_MAX-1:0] w_vmask;
    logic [PATTERN_MAX-1:0] w_top;
    logic [PATTERN_MAX-1:0] w_old   [MAX_LEVELS+1];
    logic [PATTERN_MAX-1:0] w_fresh [MAX_LEVELS+1];
    logic [PATTERN_MAX-1:0] w_init  [MAX_LEVELS+1];
    logic                   w_match;
    logic [POS_W-1:0]       n_pos;

    assign o_pop = !i_empty && (!r_out_valid || !i_stall);

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_m = MW'(1);
        end else if (32'(i_cfg.pattern_length) > 32'(PATTERN_MAX)) begin
            w_m = MW'(PATTERN_MAX);
        end else begin
            w_m = MW'(i_cfg.pattern_length);
        end
        if (32'(i_cfg.max_errors) > 32'(MAX_LEVELS)) begin
            w_k = KW'(MAX_LEVELS);
        end else begin
            w_k = KW'(i_cfg.max_errors);
        end
    end

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_eq[i]    = (r_store[i] == i_head.ch);
            w_vmask[i] = (MW'(i) < w_m);
            w_top[i]   = (MW'(i) == (w_m - MW'(1)));
        end
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_rev[i] = w_eq[PATTERN_MAX-1-i];
        end
        w_shift = MW'(PATTERN_MAX) - w_m;
        w_cmask = (w_rev >> w_shift) & w_vmask;
    end

    // Level chain: each level uses the old and new vectors of the level below.
    always_comb begin
        for (int j = 0; j <= MAX_LEVELS; j++) begin
            w_old[j] = r_lv[j] & w_vmask;
        end
        w_fresh[0] = ((w_old[0] >> 1) | w_top) & w_cmask;
        for (int j = 1; j <= MAX_LEVELS; j++) begin
            w_fresh[j] = (((w_old[j] >> 1) & w_cmask)
                         | (i_cfg.allow_insert ? w_old[j-1] : '0)
                         | (((i_cfg.allow_substitute ? w_old[j-1] : '0)
                           | (i_cfg.allow_delete ? w_fresh[j-1] : '0)) >> 1))
                         & w_vmask;
        end
        w_match = w_fresh[w_k][0];
    end

    always_comb begin
        for (int j = 0; j <= MAX_LEVELS; j++) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                w_init[j][i] = (i < int'(w_m)) && ((i + j) >= int'(w_m));
            end
        end
    end

    assign n_pos = (r_pos == '1) ? r_pos : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd == CMD_LOAD) begin
            r_store[SW'(i_head.idx)] <= i_head.ch;
        end
        if (o_pop && i_head.cmd == CMD_TEXT && w_match) begin
            r_out_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= MAX_LEVELS; j++) begin
                r_lv[j] <= '0;
            end
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_head.cmd == CMD_TEXT) begin
                r_out_valid <= w_match;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                case (i_head.cmd)
                    CMD_START: begin
                        for (int j = 0; j <= MAX_LEVELS; j++) begin
                            r_lv[j] <= w_init[j];
                        end
                        r_pos <= '0;
                    end
                    CMD_TEXT: begin
                        r_lv[0] <= w_fresh[0];
                        for (int j = 1; j <= MAX_LEVELS; j++) begin
                            if (j <= int'(w_k)) begin
                                r_lv[j] <= w_fresh[j] | w_top;
                            end
                        end
                        r_pos <= n_pos;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid              = r_out_valid;
    assign o_match_end_position = r_out_pos;

endmodule
`default_nettype wire

>>> rtl/approximate_bitap_matcher_top.sv
// A text byte passes through the queue and then the result register before its match result is valid.
// Throughput: one item per cycle while the result register is not stalled; the error-level chain is combinational.
// A two-entry queue decouples the input side from the result register.
// Reset (synchronous, active low) clears vectors, position, queue and config defaults;
// the pattern store is not cleared.
`default_nettype none
module approximate_bitap_matcher_top #(
    parameter int PATTERN_MAX = abm_pkg::PATTERN_MAX_DEF,
    parameter int MAX_LEVELS  = abm_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [abm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [abm_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [abm_pkg::CMD_W-1:0]    i_command,
    input  wire logic [abm_pkg::CHAR_W-1:0]   i_char_value,
    input  wire logic [abm_pkg::IDX_W-1:0]    i_pattern_index,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [abm_pkg::POS_W-1:0]         o_match_end_position
);
    import abm_pkg::*;

    t_cfg  r_cfg;
    logic  w_full;
    logic  w_empty;
    logic  w_push;
    logic  w_pop;
    t_item w_push_item;
    t_item w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_length   <= PLEN_W'(1);
            r_cfg.max_errors       <= '0;
            r_cfg.allow_insert     <= 1'b1;
            r_cfg.allow_delete     <= 1'b1;
            r_cfg.allow_substitute <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PATTERN_LENGTH: r_cfg.pattern_length   <= i_cfg_wdata[PLEN_W-1:0];
                CFG_MAX_ERRORS:     r_cfg.max_errors       <= i_cfg_wdata[KERR_W-1:0];
                CFG_ALLOW_INSERT:   r_cfg.allow_insert     <= i_cfg_wdata[0];
                CFG_ALLOW_DELETE:   r_cfg.allow_delete     <= i_cfg_wdata[0];
                CFG_ALLOW_SUBST:    r_cfg.allow_substitute <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    abm_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_valid         (i_valid),
        .i_command       (i_command),
        .i_char_value    (i_char_value),
        .i_pattern_index (i_pattern_index),
        .o_stall         (o_stall),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    abm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    abm_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .MAX_LEVELS  (MAX_LEVELS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_empty              (w_empty),
        .i_head               (w_head),
        .o_pop                (w_pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_match_end_position (o_match_end_position)
    );

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    a_result_from_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_pop && w_head.cmd == CMD_TEXT))
        else $error("result without a text byte");

    a_position_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_match_end_position != '0))
        else $error("zero match end position");

endmodule
`default_nettype wire
